// ===== rtl/mbrtu_pkg.sv =====
package mbrtu_pkg;

   // store sizes
   localparam int FRAME_BYTES   = 64;
   localparam int HOLDING_REGS  = 64;
   localparam int INPUT_REGS    = 16;
   localparam int COIL_COUNT    = 64;
   localparam int RESP_BYTES    = 64;
   localparam int MAX_COIL_READ = (RESP_BYTES - 5) * 8;
   localparam int MAX_REG_READ  = (RESP_BYTES - 5) / 2;
   localparam int HDR_BYTES     = 7;

   // derived widths
   localparam int FRAME_AW = $clog2(FRAME_BYTES);
   localparam int HOLD_AW  = $clog2(HOLDING_REGS);
   localparam int INPUT_AW = $clog2(INPUT_REGS);
   localparam int COIL_AW  = $clog2(COIL_COUNT);
   localparam int RX_W     = $clog2(FRAME_BYTES + 2);
   localparam int CNT_W    = $clog2(MAX_COIL_READ + 1);
   localparam int POS_W    = CNT_W + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // function codes
   localparam logic [7:0] FC_READ_COILS  = 8'd1;
   localparam logic [7:0] FC_READ_DISC   = 8'd2;
   localparam logic [7:0] FC_READ_HOLD   = 8'd3;
   localparam logic [7:0] FC_READ_INPUT  = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
   localparam logic [7:0] FC_WRITE_REG   = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

   // outcome codes
   localparam logic [2:0] OUT_OK   = 3'd0;
   localparam logic [2:0] OUT_ADDR = 3'd1;
   localparam logic [2:0] OUT_CRC  = 3'd2;
   localparam logic [2:0] OUT_FUNC = 3'd3;
   localparam logic [2:0] OUT_LONG = 3'd4;

   // command kinds passed from front to back
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_END  = 2'd1;
   localparam logic [1:0] CMD_LOAD = 2'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [3:0]  reg_idx;
      logic [15:0] reg_val;
   } cmd_type;

   // one byte of the reflected crc-16
   function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/mbrtu_ifs.sv =====
interface mbrtu_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  rx_byte;
   logic        frame_end;
   logic [3:0]  local_reg_index;
   logic [15:0] local_reg_value;

   modport source (output valid, opcode, rx_byte, frame_end, local_reg_index,
                   local_reg_value, input ready);
   modport sink (input valid, opcode, rx_byte, frame_end, local_reg_index,
                 local_reg_value, output ready);
endinterface

interface mbrtu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] resp_byte;
   logic       resp_last;
   logic [2:0] outcome;

   modport source (output valid, resp_byte, resp_last, outcome, input ready);
   modport sink (input valid, resp_byte, resp_last, outcome, output ready);
endinterface

// ===== rtl/mbrtu_ram.sv =====
module mbrtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mbrtu_front.sv =====
module mbrtu_front import mbrtu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   mbrtu_req_if.sink     req,
   output logic          cmd_valid,
   input  logic          cmd_ready,
   output cmd_type       cmd_data
);

   logic    cmd_vld_ff, cmd_vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign req.ready = !cmd_vld_ff || cmd_ready;
   assign take      = req.valid && req.ready;

   // classify the incoming transaction
   always_comb begin
      cmd_in     = cmd_ff;
      cmd_vld_in = cmd_vld_ff && !cmd_ready;
      if (take) begin
         cmd_vld_in     = 1'b1;
         cmd_in.data    = req.rx_byte;
         cmd_in.reg_idx = req.local_reg_index;
         cmd_in.reg_val = req.local_reg_value;
         priority if (req.opcode) begin
            cmd_in.kind = CMD_LOAD;
         end else if (req.frame_end) begin
            cmd_in.kind = CMD_END;
         end else begin
            cmd_in.kind = CMD_BYTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= cmd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_vld_ff;
   assign cmd_data  = cmd_ff;

endmodule

// ===== rtl/mbrtu_queue.sv =====
module mbrtu_queue import mbrtu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mbrtu_back.sv =====
module mbrtu_back import mbrtu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  slave_address,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_data,
   mbrtu_rsp_if.source rsp
);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CHECK    = 4'd1;
   localparam logic [3:0] S_STATUS   = 4'd2;
   localparam logic [3:0] S_HDR      = 4'd3;
   localparam logic [3:0] S_COIL_RD  = 4'd4;
   localparam logic [3:0] S_COIL_USE = 4'd5;
   localparam logic [3:0] S_REG_RD   = 4'd6;
   localparam logic [3:0] S_REG_HI   = 4'd7;
   localparam logic [3:0] S_REG_LO   = 4'd8;
   localparam logic [3:0] S_W15_RD   = 4'd9;
   localparam logic [3:0] S_W15_USE  = 4'd10;
   localparam logic [3:0] S_W16_RD1  = 4'd11;
   localparam logic [3:0] S_W16_RD2  = 4'd12;
   localparam logic [3:0] S_W16_USE  = 4'd13;
   localparam logic [3:0] S_CRC_LO   = 4'd14;
   localparam logic [3:0] S_CRC_HI   = 4'd15;

   logic [3:0]       state_ff, state_in;
   logic [RX_W-1:0]  rx_count_ff, rx_count_in, len_ff, len_in, rx_next;
   logic [7:0]       hdr_ff [HDR_BYTES];
   logic [7:0]       hdr_in [HDR_BYTES];
   logic [7:0]       fbm [HDR_BYTES];
   logic [7:0]       last_b_ff, last_b_in, prev_b_ff, prev_b_in;
   logic [15:0]      crc_ff, crc_in, crc1_ff, crc1_in, crc2_ff, crc2_in, crc_base;
   logic [7:0]       func_ff, func_in, cbyte_ff, cbyte_in;
   logic [15:0]      addr_ff, addr_in, data_ff, data_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, i_ff, i_in, i_next;
   logic [2:0]       byte_idx_ff, byte_idx_in, hdr_last_ff, hdr_last_in;
   logic [7:0]       acc_ff, acc_in, acc_new, hi_ff, hi_in;
   logic             inrange_ff, inrange_in, vld_q_ff, vld_q_in, flag_ff, flag_in;
   logic [15:0]      inreg_q_ff, inreg_q_in, rcrc_ff, rcrc_in, reg_val;
   logic [2:0]       outcome_ff, outcome_in;
   logic [15:0]      input_store_ff [INPUT_REGS];
   logic [15:0]      input_store_in [INPUT_REGS];
   logic [COIL_COUNT-1:0]   coil_vld_ff, coil_vld_in;
   logic [HOLDING_REGS-1:0] hold_vld_ff, hold_vld_in;
   logic             rsp_vld_ff, rsp_vld_in, rsp_last_ff, rsp_last_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [2:0]       rsp_outcome_ff, rsp_outcome_in;

   // frame check decode
   logic [15:0]      chk_addr, chk_data;
   logic [7:0]       chk_func;
   logic [CNT_W-1:0] coil_cnt, reg_cnt;
   logic [16:0]      a_sum;
   logic [POS_W-1:0] pos_a, pos_b;
   logic             i_last, out_free, w15_go, w16_go, coil_bit, frame_bit;
   logic [3:0]       after_hdr;

   // emission
   logic             emit_req, emit_en, emit_last, emit_data;
   logic [7:0]       emit_byte;
   logic [2:0]       emit_out;

   // memory ports
   logic                frame_wr_en, frame_rd_en;
   logic [FRAME_AW-1:0] frame_wr_addr, frame_rd_addr;
   logic [7:0]          frame_q;
   logic                coil_wr_en, coil_rd_en;
   logic [COIL_AW-1:0]  coil_wr_addr, coil_rd_addr;
   logic [0:0]          coil_wr_data, coil_q;
   logic                hold_wr_en, hold_rd_en;
   logic [HOLD_AW-1:0]  hold_wr_addr, hold_rd_addr;
   logic [15:0]         hold_wr_data, hold_q;

   assign cmd_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_vld_ff || rsp.ready;

   // header bytes read as zero past the received length
   always_comb begin
      for (int p = 0; p < HDR_BYTES; p++) begin
         fbm[p] = (RX_W'(p) < len_ff) ? hdr_ff[p] : 8'd0;
      end
   end

   assign chk_func = fbm[1];
   assign chk_addr = {fbm[2], fbm[3]};
   assign chk_data = {fbm[4], fbm[5]};
   assign coil_cnt = (chk_data > 16'(MAX_COIL_READ)) ? CNT_W'(MAX_COIL_READ)
                                                     : CNT_W'(chk_data);
   assign reg_cnt  = (chk_data > 16'(MAX_REG_READ)) ? CNT_W'(MAX_REG_READ)
                                                    : CNT_W'(chk_data);

   assign a_sum   = 17'(addr_ff) + 17'(i_ff);
   assign i_next  = i_ff + 1'b1;
   assign i_last  = (i_next == cnt_ff);
   assign pos_a   = (func_ff == FC_WRITE_COILS) ? POS_W'(HDR_BYTES) + POS_W'(i_ff >> 3)
                                                : POS_W'(HDR_BYTES) + POS_W'({i_ff, 1'b0});
   assign pos_b   = pos_a + 1'b1;
   assign w15_go  = (16'(i_ff) < data_ff) && (a_sum < 17'(COIL_COUNT));
   assign w16_go  = (i_ff < cnt_ff) && (a_sum < 17'(HOLDING_REGS));
   assign coil_bit  = inrange_ff && vld_q_ff && coil_q[0];
   assign acc_new   = acc_ff | (8'(coil_bit) << i_ff[2:0]);
   assign reg_val   = !inrange_ff ? 16'd0
                    : (func_ff == FC_READ_HOLD) ? (vld_q_ff ? hold_q : 16'd0) : inreg_q_ff;
   assign frame_bit = flag_ff ? frame_q[i_ff[2:0]] : 1'b0;

   // where the header goes next
   always_comb begin
      priority if (func_ff == FC_READ_COILS || func_ff == FC_READ_DISC) begin
         after_hdr = (cnt_ff == '0) ? S_CRC_LO : S_COIL_RD;
      end else if (func_ff == FC_READ_HOLD || func_ff == FC_READ_INPUT) begin
         after_hdr = (cnt_ff == '0) ? S_CRC_LO : S_REG_RD;
      end else begin
         after_hdr = S_CRC_LO;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      rx_count_in = rx_count_ff;
      len_in      = len_ff;
      hdr_in      = hdr_ff;
      last_b_in   = last_b_ff;
      prev_b_in   = prev_b_ff;
      crc_in      = crc_ff;
      crc1_in     = crc1_ff;
      crc2_in     = crc2_ff;
      func_in     = func_ff;
      cbyte_in    = cbyte_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      byte_idx_in = byte_idx_ff;
      hdr_last_in = hdr_last_ff;
      acc_in      = acc_ff;
      hi_in       = hi_ff;
      inrange_in  = inrange_ff;
      vld_q_in    = vld_q_ff;
      flag_in     = flag_ff;
      inreg_q_in  = inreg_q_ff;
      rcrc_in     = rcrc_ff;
      outcome_in  = outcome_ff;
      input_store_in = input_store_ff;
      coil_vld_in = coil_vld_ff;
      hold_vld_in = hold_vld_ff;
      rx_next     = (rx_count_ff <= RX_W'(FRAME_BYTES)) ? rx_count_ff + 1'b1 : rx_count_ff;
      crc_base    = (rx_count_ff == '0) ? CRC_INIT : crc_ff;

      emit_req  = 1'b0;
      emit_last = 1'b0;
      emit_data = 1'b0;
      emit_byte = 8'd0;
      emit_out  = OUT_OK;

      frame_wr_en   = 1'b0;
      frame_wr_addr = rx_count_ff[FRAME_AW-1:0];
      frame_rd_en   = 1'b0;
      frame_rd_addr = pos_a[FRAME_AW-1:0];
      coil_wr_en    = 1'b0;
      coil_wr_addr  = a_sum[COIL_AW-1:0];
      coil_wr_data  = frame_bit;
      coil_rd_en    = 1'b0;
      coil_rd_addr  = a_sum[COIL_AW-1:0];
      hold_wr_en    = 1'b0;
      hold_wr_addr  = a_sum[HOLD_AW-1:0];
      hold_wr_data  = {hi_ff, (flag_ff ? frame_q : 8'd0)};
      hold_rd_en    = 1'b0;
      hold_rd_addr  = a_sum[HOLD_AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.kind == CMD_LOAD) begin
                  if (cmd_data.reg_idx < INPUT_REGS) begin
                     input_store_in[cmd_data.reg_idx[INPUT_AW-1:0]] = cmd_data.reg_val;
                  end
               end else begin
                  // store the byte and keep crc over all, all-but-one, all-but-two
                  frame_wr_en = (rx_count_ff < RX_W'(FRAME_BYTES));
                  if (rx_count_ff < RX_W'(HDR_BYTES)) begin
                     hdr_in[rx_count_ff[2:0]] = cmd_data.data;
                  end
                  crc_in    = crc_byte(crc_base, cmd_data.data);
                  crc1_in   = crc_base;
                  crc2_in   = crc1_ff;
                  prev_b_in = last_b_ff;
                  last_b_in = cmd_data.data;
                  if (cmd_data.kind == CMD_END) begin
                     len_in      = rx_next;
                     rx_count_in = '0;
                     state_in    = S_CHECK;
                  end else begin
                     rx_count_in = rx_next;
                  end
               end
            end
         end

         S_CHECK: begin
            func_in     = chk_func;
            addr_in     = chk_addr;
            data_in     = chk_data;
            i_in        = '0;
            acc_in      = 8'd0;
            byte_idx_in = 3'd0;
            rcrc_in     = CRC_INIT;
            hdr_last_in = 3'd5;
            priority if (len_ff > RX_W'(FRAME_BYTES)) begin
               outcome_in = OUT_LONG;
               state_in   = S_STATUS;
            end else if (fbm[0] != slave_address) begin
               outcome_in = OUT_ADDR;
               state_in   = S_STATUS;
            end else if (len_ff < RX_W'(4)) begin
               outcome_in = OUT_CRC;
               state_in   = S_STATUS;
            end else if (crc2_ff[7:0] != prev_b_ff || crc2_ff[15:8] != last_b_ff) begin
               outcome_in = OUT_CRC;
               state_in   = S_STATUS;
            end else if (chk_func == FC_READ_COILS || chk_func == FC_READ_DISC) begin
               cnt_in      = coil_cnt;
               cbyte_in    = 8'((coil_cnt + 3'd7) >> 3);
               hdr_last_in = 3'd2;
               state_in    = S_HDR;
            end else if (chk_func == FC_READ_HOLD || chk_func == FC_READ_INPUT) begin
               cnt_in      = reg_cnt;
               cbyte_in    = 8'({reg_cnt, 1'b0});
               hdr_last_in = 3'd2;
               state_in    = S_HDR;
            end else if (chk_func == FC_WRITE_COIL) begin
               coil_wr_en   = (17'(chk_addr) < 17'(COIL_COUNT));
               coil_wr_addr = chk_addr[COIL_AW-1:0];
               coil_wr_data = (chk_data != 16'd0);
               if (coil_wr_en) begin
                  coil_vld_in[chk_addr[COIL_AW-1:0]] = 1'b1;
               end
               state_in = S_HDR;
            end else if (chk_func == FC_WRITE_REG) begin
               hold_wr_en   = (17'(chk_addr) < 17'(HOLDING_REGS));
               hold_wr_addr = chk_addr[HOLD_AW-1:0];
               hold_wr_data = chk_data;
               if (hold_wr_en) begin
                  hold_vld_in[chk_addr[HOLD_AW-1:0]] = 1'b1;
               end
               state_in = S_HDR;
            end else if (chk_func == FC_WRITE_COILS) begin
               state_in = S_W15_RD;
            end else if (chk_func == FC_WRITE_REGS) begin
               cnt_in   = CNT_W'(fbm[6] >> 1);
               state_in = S_W16_RD1;
            end else begin
               outcome_in = OUT_FUNC;
               state_in   = S_STATUS;
            end
         end

         S_STATUS: begin
            emit_req  = 1'b1;
            emit_last = 1'b1;
            emit_out  = outcome_ff;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         S_HDR: begin
            emit_req  = 1'b1;
            emit_data = 1'b1;
            unique case (byte_idx_ff)
               3'd0:    emit_byte = slave_address;
               3'd1:    emit_byte = func_ff;
               3'd2:    emit_byte = (hdr_last_ff == 3'd2) ? cbyte_ff : addr_ff[15:8];
               3'd3:    emit_byte = addr_ff[7:0];
               3'd4:    emit_byte = data_ff[15:8];
               default: emit_byte = data_ff[7:0];
            endcase
            if (out_free) begin
               byte_idx_in = byte_idx_ff + 1'b1;
               if (byte_idx_ff == hdr_last_ff) begin
                  state_in = after_hdr;
               end
            end
         end

         S_COIL_RD: begin
            coil_rd_en = 1'b1;
            inrange_in = (a_sum < 17'(COIL_COUNT));
            vld_q_in   = coil_vld_ff[a_sum[COIL_AW-1:0]];
            state_in   = S_COIL_USE;
         end

         S_COIL_USE: begin
            if (i_ff[2:0] == 3'd7 || i_last) begin
               emit_req  = 1'b1;
               emit_data = 1'b1;
               emit_byte = acc_new;
               if (out_free) begin
                  acc_in   = 8'd0;
                  i_in     = i_next;
                  state_in = i_last ? S_CRC_LO : S_COIL_RD;
               end
            end else begin
               acc_in   = acc_new;
               i_in     = i_next;
               state_in = S_COIL_RD;
            end
         end

         S_REG_RD: begin
            hold_rd_en = 1'b1;
            inrange_in = (func_ff == FC_READ_HOLD) ? (a_sum < 17'(HOLDING_REGS))
                                                   : (a_sum < 17'(INPUT_REGS));
            vld_q_in   = hold_vld_ff[a_sum[HOLD_AW-1:0]];
            inreg_q_in = input_store_ff[a_sum[INPUT_AW-1:0]];
            state_in   = S_REG_HI;
         end

         S_REG_HI: begin
            emit_req  = 1'b1;
            emit_data = 1'b1;
            emit_byte = reg_val[15:8];
            if (out_free) begin
               state_in = S_REG_LO;
            end
         end

         S_REG_LO: begin
            emit_req  = 1'b1;
            emit_data = 1'b1;
            emit_byte = reg_val[7:0];
            if (out_free) begin
               i_in     = i_next;
               state_in = i_last ? S_CRC_LO : S_REG_RD;
            end
         end

         S_W15_RD: begin
            if (w15_go) begin
               frame_rd_en = 1'b1;
               flag_in     = (pos_a < POS_W'(len_ff));
               state_in    = S_W15_USE;
            end else begin
               state_in = S_HDR;
            end
         end

         S_W15_USE: begin
            coil_wr_en = 1'b1;
            coil_vld_in[a_sum[COIL_AW-1:0]] = 1'b1;
            i_in     = i_next;
            state_in = S_W15_RD;
         end

         S_W16_RD1: begin
            if (w16_go) begin
               frame_rd_en = 1'b1;
               flag_in     = (pos_a < POS_W'(len_ff));
               state_in    = S_W16_RD2;
            end else begin
               state_in = S_HDR;
            end
         end

         S_W16_RD2: begin
            hi_in         = flag_ff ? frame_q : 8'd0;
            frame_rd_en   = 1'b1;
            frame_rd_addr = pos_b[FRAME_AW-1:0];
            flag_in       = (pos_b < POS_W'(len_ff));
            state_in      = S_W16_USE;
         end

         S_W16_USE: begin
            hold_wr_en = 1'b1;
            hold_vld_in[a_sum[HOLD_AW-1:0]] = 1'b1;
            i_in     = i_next;
            state_in = S_W16_RD1;
         end

         S_CRC_LO: begin
            emit_req  = 1'b1;
            emit_byte = rcrc_ff[7:0];
            if (out_free) begin
               state_in = S_CRC_HI;
            end
         end

         S_CRC_HI: begin
            emit_req  = 1'b1;
            emit_last = 1'b1;
            emit_byte = rcrc_ff[15:8];
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      emit_en = emit_req && out_free;
      if (emit_en && emit_data) begin
         rcrc_in = crc_byte(rcrc_ff, emit_byte);
      end
   end

   // output register
   always_comb begin
      rsp_vld_in     = rsp_vld_ff && !rsp.ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_outcome_in = rsp_outcome_ff;
      if (emit_en) begin
         rsp_vld_in     = 1'b1;
         rsp_byte_in    = emit_byte;
         rsp_last_in    = emit_last;
         rsp_outcome_in = emit_out;
      end
   end

   // control state and stores with a reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rx_count_ff    <= '0;
         rsp_vld_ff     <= 1'b0;
         coil_vld_ff    <= '0;
         hold_vld_ff    <= '0;
         for (int r = 0; r < INPUT_REGS; r++) begin
            input_store_ff[r] <= 16'd0;
         end
      end else begin
         state_ff       <= state_in;
         rx_count_ff    <= rx_count_in;
         rsp_vld_ff     <= rsp_vld_in;
         coil_vld_ff    <= coil_vld_in;
         hold_vld_ff    <= hold_vld_in;
         input_store_ff <= input_store_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff         <= len_in;
      hdr_ff         <= hdr_in;
      last_b_ff      <= last_b_in;
      prev_b_ff      <= prev_b_in;
      crc_ff         <= crc_in;
      crc1_ff        <= crc1_in;
      crc2_ff        <= crc2_in;
      func_ff        <= func_in;
      cbyte_ff       <= cbyte_in;
      addr_ff        <= addr_in;
      data_ff        <= data_in;
      cnt_ff         <= cnt_in;
      i_ff           <= i_in;
      byte_idx_ff    <= byte_idx_in;
      hdr_last_ff    <= hdr_last_in;
      acc_ff         <= acc_in;
      hi_ff          <= hi_in;
      inrange_ff     <= inrange_in;
      vld_q_ff       <= vld_q_in;
      flag_ff        <= flag_in;
      inreg_q_ff     <= inreg_q_in;
      rcrc_ff        <= rcrc_in;
      outcome_ff     <= outcome_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   // stores
   mbrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_wr_en),
      .wr_addr (frame_wr_addr),
      .wr_data (cmd_data.data),
      .rd_en   (frame_rd_en),
      .rd_addr (frame_rd_addr),
      .rd_data (frame_q)
   );

   mbrtu_ram #(.WIDTH(1), .DEPTH(COIL_COUNT)) u_coil_ram (
      .clock   (clock),
      .wr_en   (coil_wr_en),
      .wr_addr (coil_wr_addr),
      .wr_data (coil_wr_data),
      .rd_en   (coil_rd_en),
      .rd_addr (coil_rd_addr),
      .rd_data (coil_q)
   );

   mbrtu_ram #(.WIDTH(16), .DEPTH(HOLDING_REGS)) u_hold_ram (
      .clock   (clock),
      .wr_en   (hold_wr_en),
      .wr_addr (hold_wr_addr),
      .wr_data (hold_wr_data),
      .rd_en   (hold_rd_en),
      .rd_addr (hold_rd_addr),
      .rd_data (hold_q)
   );

   assign rsp.valid     = rsp_vld_ff;
   assign rsp.resp_byte = rsp_byte_ff;
   assign rsp.resp_last = rsp_last_ff;
   assign rsp.outcome   = rsp_outcome_ff;

`ifndef ASSERT_OFF
   a_rx_cap : assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= RX_W'(FRAME_BYTES + 1))
      else $error("frame byte count beyond saturation");

   a_status_single : assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_outcome_ff != OUT_OK) |-> (rsp_last_ff && rsp_byte_ff == 8'd0))
      else $error("status transaction not a lone zero byte");

   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      (emit_en && emit_last) |=> (state_ff == S_IDLE))
      else $error("sequencer busy after final transaction");

   a_no_rx_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !frame_wr_en)
      else $error("frame store written during execution");
`endif

endmodule

// ===== rtl/modbus_rtu_slave_engine_core.sv =====
// channel   dir  fields                                                      handshake
// req_ch    in   opcode, rx_byte, frame_end, local_reg_index, local_reg_value valid/ready
// rsp_ch    out  resp_byte, resp_last, outcome                              valid/ready
// csr       in   csr_wr_data = slave_address                                 csr_wr_en
//
// a frame byte or local load is taken in the back sequencer's idle state, after passing
// through the front register and the four-entry command queue
// at frame end: a check state, then read and use states per coil read or coil write,
// read, high-byte and low-byte states per register read, two frame reads and a write
// state per register write, and response bytes that wait while rsp_ch is not ready
// reset (synchronous) clears the input store and the store valid bits, so the stores
// read as zero, and sets slave_address to 1; req_ch stalls only when the queue fills
module modbus_rtu_slave_engine_core import mbrtu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mbrtu_req_if.sink  req_ch,
   mbrtu_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0] slave_addr_ff, slave_addr_in;
   logic       f_valid, f_ready, q_valid, q_ready;
   cmd_type    f_data, q_data;

   // station address register
   assign slave_addr_in = csr_wr_en ? csr_wr_data : slave_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= 8'd1;
      end else begin
         slave_addr_ff <= slave_addr_in;
      end
   end

   mbrtu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd_data  (f_data)
   );

   mbrtu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   mbrtu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .slave_address (slave_addr_ff),
      .cmd_valid     (q_valid),
      .cmd_ready     (q_ready),
      .cmd_data      (q_data),
      .rsp           (rsp_ch)
   );

endmodule
